@@ sv/hkrt_pkg.sv @@
// Package with the constants and request codes of the HID keyboard report tracker.
`default_nettype none
package hkrt_pkg;

	// Held-key list depth and number of key slots in one report
	localparam int KEY_SLOTS    = 6;
	localparam int REPORT_SLOTS = 6;
	localparam int CNT_W        = $clog2(KEY_SLOTS + 1);

	localparam int KEY_W = 8;
	localparam int MOD_W = 8;
	localparam int REQ_W = 2;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_PRESS       = 2'd0;
	localparam logic [REQ_W-1:0] REQ_RELEASE     = 2'd1;
	localparam logic [REQ_W-1:0] REQ_RELEASE_ALL = 2'd2;
	localparam logic [REQ_W-1:0] REQ_UNUSED      = 2'd3;

	localparam logic [KEY_W-1:0] KEY_NONE = 8'h00;

endpackage
`default_nettype wire

@@ sv/hid_keyboard_report_tracker.sv @@
// Top level of the HID boot keyboard report tracker: modifier byte and held-key list.
// An event is taken into the event register; its report, marked by done, is registered from there.
// Throughput: one event per cycle; busy is always low, since the list update is one
// compare-and-shift pass over the six slots between the event register and the state.
// Reset: arst_n clears the modifier byte, the held-key list, its count and enabled.
// Reports cannot be stalled: done is high for exactly one cycle per report.
`default_nettype none
module hid_keyboard_report_tracker import hkrt_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_wdata,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [REQ_W-1:0] req_type,
	input  wire logic [KEY_W-1:0] key_code,
	input  wire logic [MOD_W-1:0] modifier_mask,
	output logic                  done,
	output logic [MOD_W-1:0]      modifiers,
	output logic [KEY_W-1:0]      key_slot_0,
	output logic [KEY_W-1:0]      key_slot_1,
	output logic [KEY_W-1:0]      key_slot_2,
	output logic [KEY_W-1:0]      key_slot_3,
	output logic [KEY_W-1:0]      key_slot_4,
	output logic [KEY_W-1:0]      key_slot_5
);

	logic                  enabled_q;
	logic                  valid_s1;
	logic [REQ_W-1:0]      req_s1;
	logic [KEY_W-1:0]      code_s1;
	logic [MOD_W-1:0]      mask_s1;
	logic                  done_q;
	logic [MOD_W-1:0]      mods_q;
	logic [KEY_W-1:0]      slots_q [KEY_SLOTS];
	logic [CNT_W-1:0]      count_q;

	logic [MOD_W-1:0]      mods_d;
	logic [KEY_W-1:0]      slots_d [KEY_SLOTS];
	logic [CNT_W-1:0]      count_d;
	logic [KEY_SLOTS-1:0]  hit;
	logic [KEY_SLOTS-1:0]  shift_from;
	logic                  any_hit;
	logic                  list_full;
	logic [KEY_W-1:0]      report [REPORT_SLOTS];

	// Events are never held off
	assign busy = 1'b0;

	// Write the enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
		end else if (cfg_we) begin
			enabled_q <= cfg_wdata;
		end
	end

	// Capture the event; drop it when disabled or of an unused request code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && enabled_q && (req_type != REQ_UNUSED);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			req_s1  <= req_type;
			code_s1 <= key_code;
			mask_s1 <= modifier_mask;
		end
	end

	// Compare the code against every slot; empty slots hold zero
	always_comb begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			hit[i] = (slots_q[i] == code_s1) && (code_s1 != KEY_NONE);
		end
		any_hit   = |hit;
		list_full = (count_q >= CNT_W'(KEY_SLOTS));
		// Slots at or after the released code take the next slot's value
		shift_from[0] = hit[0];
		for (int i = 1; i < KEY_SLOTS; i++) begin
			shift_from[i] = shift_from[i-1] | hit[i];
		end
	end

	// Next state for the event in stage one
	always_comb begin
		mods_d  = mods_q;
		count_d = count_q;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			slots_d[i] = slots_q[i];
		end
		if (req_s1 == REQ_RELEASE_ALL) begin
			mods_d  = '0;
			count_d = '0;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				slots_d[i] = KEY_NONE;
			end
		end else if (mask_s1 != '0) begin
			if (req_s1 == REQ_PRESS) begin
				mods_d = mods_q | mask_s1;
			end else begin
				mods_d = mods_q & ~mask_s1;
			end
		end else if (req_s1 == REQ_PRESS) begin
			// Append a new code at the end of the list if there is room
			if (code_s1 != KEY_NONE && !any_hit && !list_full) begin
				for (int i = 0; i < KEY_SLOTS; i++) begin
					if (CNT_W'(i) == count_q) begin
						slots_d[i] = code_s1;
					end
				end
				count_d = count_q + 1'b1;
			end
		end else if (any_hit) begin
			// Remove the code and close the gap, zero-filling the last slot
			for (int i = 0; i < KEY_SLOTS; i++) begin
				if (shift_from[i]) begin
					slots_d[i] = (i + 1 < KEY_SLOTS) ? slots_q[(i + 1) % KEY_SLOTS] : KEY_NONE;
				end
			end
			count_d = count_q - 1'b1;
		end
	end

	// Advance the keyboard state and raise the report strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			mods_q  <= '0;
			count_q <= '0;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				slots_q[i] <= KEY_NONE;
			end
		end else begin
			done_q <= valid_s1;
			if (valid_s1) begin
				mods_q  <= mods_d;
				count_q <= count_d;
				for (int i = 0; i < KEY_SLOTS; i++) begin
					slots_q[i] <= slots_d[i];
				end
			end
		end
	end

	// Map the held list onto the report slots; slots past the list read zero
	for (genvar g = 0; g < REPORT_SLOTS; g++) begin : g_report
		if (g < KEY_SLOTS) begin : g_used
			assign report[g] = slots_q[g];
		end else begin : g_empty
			assign report[g] = KEY_NONE;
		end
	end

	assign done       = done_q;
	assign modifiers  = mods_q;
	assign key_slot_0 = report[0];
	assign key_slot_1 = report[1];
	assign key_slot_2 = report[2];
	assign key_slot_3 = report[3];
	assign key_slot_4 = report[4];
	assign key_slot_5 = report[5];

	// A report follows only an event held in stage one
	a_done_follows_event: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(valid_s1))
		else $error("report strobe without a captured event");

	// The held count never exceeds the list depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(KEY_SLOTS))
		else $error("held-key count beyond list depth");

	// Release all leaves an empty report
	a_release_all_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && req_s1 == REQ_RELEASE_ALL) |=> (count_q == '0 && mods_q == '0
			&& slots_q[0] == KEY_NONE))
		else $error("release all left state behind");

	// The count changes by at most one per event
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && req_s1 != REQ_RELEASE_ALL) |=>
			(count_q == $past(count_q) || count_q == $past(count_q) + 1'b1
			|| count_q == $past(count_q) - 1'b1))
		else $error("held-key count jumped");

	// An empty list shows no key in the first slot
	a_empty_first_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (slots_q[0] == KEY_NONE))
		else $error("empty list with a nonzero first slot");

endmodule
`default_nettype wire
